@@ design/mrf_pkg.sv @@
// ---------------------------------------------------------------------------
// mrf_pkg - shared types and constants of the Modbus request framer
// Function codes, CRC constants, the frame command passed from the front end
// to the emitter, and the queue status bundle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrf_pkg;

  localparam logic [7:0]  FC_READ_COILS   = 8'h01;
  localparam logic [7:0]  FC_READ_INPUTS  = 8'h02;
  localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FC_WRITE_COIL   = 8'h05;
  localparam logic [7:0]  FC_WRITE_REG    = 8'h06;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;

  localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;

  localparam logic        KIND_HEADER     = 1'b0;

  // default depth of the command queue between front end and emitter
  localparam int          QUEUE_DEPTH     = 2;

  // one frame segment: up to seven payload bytes, optionally followed by CRC
  typedef struct packed {
    logic            restart;   // reset the running CRC before the first byte
    logic [2:0]      nbytes;
    logic [7:0][7:0] bytes;     // byte 0 goes first; slot 7 is never used
    logic            add_crc;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic at_start;             // emitter sits at the first byte of a command
    logic crc_clear;            // running CRC holds its initial value
  } emit_stat_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY_REFL;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

@@ design/modbus_request_framer.sv @@
// ---------------------------------------------------------------------------
// modbus_request_framer - Modbus RTU request framer
// Turns header and data-word items into the byte stream of an RTU request
// frame with its running CRC-16 appended.
// ---------------------------------------------------------------------------
// Input channel (in_*): one item per beat, valid/ready. Headers of function
// 1, 2, 3, 5 and 6 produce a full eight-byte frame; function 16 produces a
// seven-byte header (with CRC if the count is zero) and each following data
// word two bytes, the last word also the two CRC bytes. Unsupported headers
// and stray data words produce nothing.
// Output channel (out_*): one frame byte per beat, out_frame_end marks the
// CRC high byte closing a frame.
// The first byte of an item passes through the command queue and the output
// register. Throughput: one byte per cycle while the receiver does not stall;
// an item has 2 to 9 bytes, and the emitter's byte walk sets the rate. The
// classifier takes a new item every cycle while the command queue has room.
// Reset clears the queue, the open-write state and the output valid flag, and
// sets the CRC to all ones. When the receiver stalls the output register
// holds, the emitter stops and the queue fills before in_ready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_request_framer #(
  parameter int QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_slave_address,
  input  logic [7:0]  in_function_code,
  input  logic [15:0] in_start_address,
  input  logic [15:0] in_quantity,
  input  logic [15:0] in_data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_end
);

  mrf_pkg::cmd_t       push_cmd, head_cmd;
  mrf_pkg::q_stat_t    q_stat;
  mrf_pkg::emit_stat_t e_stat;
  logic                q_push, q_pop;

  assign in_ready = !q_stat.full;

  mrf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (in_valid && in_ready),
    .in_kind          (in_kind),
    .in_slave_address (in_slave_address),
    .in_function_code (in_function_code),
    .in_start_address (in_start_address),
    .in_quantity      (in_quantity),
    .in_data_word     (in_data_word),
    .push             (q_push),
    .cmd              (push_cmd)
  );

  mrf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (push_cmd),
    .pop    (q_pop),
    .rd_cmd (head_cmd),
    .stat   (q_stat)
  );

  mrf_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (head_cmd),
    .cmd_valid      (!q_stat.empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end),
    .stat           (e_stat)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("command popped from an empty queue");

  a_pop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> e_stat.at_start) else $error("emitter not rewound after a command");

  a_end_clears_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head_cmd.add_crc) |=> e_stat.crc_clear)
    else $error("CRC not reinitialised after frame end");
`endif

endmodule

@@ design/mrf_front.sv @@
// ---------------------------------------------------------------------------
// mrf_front - request classifier
// Decodes header and data-word items into frame commands and tracks the
// state of an open multi-register write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          in_kind,
  input  logic [7:0]    in_slave_address,
  input  logic [7:0]    in_function_code,
  input  logic [15:0]   in_start_address,
  input  logic [15:0]   in_quantity,
  input  logic [15:0]   in_data_word,
  output logic          push,
  output mrf_pkg::cmd_t cmd
);

  logic [7:0] words_left_r, words_left_nxt;
  logic       write_open_r, write_open_nxt;
  logic       keep;
  logic [7:0] cnt;

  assign cnt = in_quantity[7:0];

  always_comb begin
    cmd            = '0;
    keep           = 1'b0;
    words_left_nxt = words_left_r;
    write_open_nxt = write_open_r;
    if (in_kind != mrf_pkg::KIND_HEADER) begin
      if (write_open_r) begin
        keep             = 1'b1;
        cmd.nbytes       = 3'd2;
        cmd.bytes[0]     = in_data_word[15:8];
        cmd.bytes[1]     = in_data_word[7:0];
        words_left_nxt   = words_left_r - 8'd1;
        cmd.add_crc      = (words_left_r == 8'd1);
        if (words_left_r == 8'd1) write_open_nxt = 1'b0;
      end
    end else begin
      // any header abandons an open write
      words_left_nxt = '0;
      write_open_nxt = 1'b0;
      cmd.restart    = 1'b1;
      cmd.bytes[0]   = in_slave_address;
      cmd.bytes[1]   = in_function_code;
      cmd.bytes[2]   = in_start_address[15:8];
      cmd.bytes[3]   = in_start_address[7:0];
      unique case (in_function_code)
        mrf_pkg::FC_READ_COILS, mrf_pkg::FC_READ_INPUTS, mrf_pkg::FC_READ_HOLDING: begin
          keep         = 1'b1;
          cmd.nbytes   = 3'd6;
          cmd.bytes[4] = in_quantity[15:8];
          cmd.bytes[5] = in_quantity[7:0];
          cmd.add_crc  = 1'b1;
        end
        mrf_pkg::FC_WRITE_COIL, mrf_pkg::FC_WRITE_REG: begin
          keep         = 1'b1;
          cmd.nbytes   = 3'd6;
          cmd.bytes[4] = in_data_word[15:8];
          cmd.bytes[5] = in_data_word[7:0];
          cmd.add_crc  = 1'b1;
        end
        mrf_pkg::FC_WRITE_MULTI: begin
          keep         = 1'b1;
          cmd.nbytes   = 3'd7;
          cmd.bytes[4] = 8'h00;
          cmd.bytes[5] = cnt;
          cmd.bytes[6] = {cnt[6:0], 1'b0};
          cmd.add_crc  = (cnt == 8'd0);
          if (cnt != 8'd0) begin
            words_left_nxt = cnt;
            write_open_nxt = 1'b1;
          end
        end
        default: keep = 1'b0;
      endcase
    end
  end

  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_left_r <= '0;
      write_open_r <= 1'b0;
    end else if (accept) begin
      words_left_r <= words_left_nxt;
      write_open_r <= write_open_nxt;
    end
  end

endmodule

@@ design/mrf_queue.sv @@
// ---------------------------------------------------------------------------
// mrf_queue - command queue
// Small FIFO of frame commands between the classifier and the emitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrf_queue #(
  parameter int DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mrf_pkg::cmd_t    wr_cmd,
  input  logic             pop,
  output mrf_pkg::cmd_t    rd_cmd,
  output mrf_pkg::q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mrf_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_cmd     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ design/mrf_emit.sv @@
// ---------------------------------------------------------------------------
// mrf_emit - byte emitter
// Walks the head command byte by byte, folds each byte into the running CRC-16 and appends
// the CRC if add_crc is set; one beat per cycle into the output register while the receiver does not stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrf_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  mrf_pkg::cmd_t       cmd,
  input  logic                cmd_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_frame_byte,
  output logic                out_frame_end,
  output mrf_pkg::emit_stat_t stat
);

  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt, crc_in;
  logic        out_valid_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        end_r, end_nxt;
  logic        advance, is_last;
  logic [3:0]  nb;

  assign nb      = {1'b0, cmd.nbytes};
  assign advance = cmd_valid && (!out_valid_r || out_ready);
  assign crc_in  = (idx_r == 4'd0 && cmd.restart) ? mrf_pkg::CRC_INIT : crc_r;

  always_comb begin
    byte_nxt = cmd.bytes[idx_r[2:0]];
    end_nxt  = 1'b0;
    crc_nxt  = crc_in;
    is_last  = 1'b0;
    priority if (idx_r < nb) begin
      crc_nxt = mrf_pkg::crc_feed(crc_in, byte_nxt);
      is_last = (idx_r == nb - 4'd1) && !cmd.add_crc;
    end else if (idx_r == nb) begin
      byte_nxt = crc_in[7:0];
    end else begin
      byte_nxt = crc_in[15:8];
      end_nxt  = 1'b1;
      crc_nxt  = mrf_pkg::CRC_INIT;
      is_last  = 1'b1;
    end
    idx_nxt = is_last ? 4'd0 : idx_r + 4'd1;
  end

  assign pop = advance && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= mrf_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        idx_r       <= idx_nxt;
        crc_r       <= crc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= byte_nxt;
      end_r  <= end_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_frame_end  = end_r;
  assign stat.at_start  = (idx_r == 4'd0);
  assign stat.crc_clear = (crc_r == mrf_pkg::CRC_INIT);

endmodule

@@ dv/frame_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_checker - byte stream predictor and checker for the request framer
// Watches both channels of the framer. Every accepted request beat is run
// through a local model of the framer (running CRC-16, open multi-register
// write, words still due), which queues the frame bytes it should produce.
// Every accepted output beat is compared against the oldest queued byte.
// ---------------------------------------------------------------------------

module frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_slave_address,
  input  logic [7:0]  in_function_code,
  input  logic [15:0] in_start_address,
  input  logic [15:0] in_quantity,
  input  logic [15:0] in_data_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_frame_byte,
  input  logic        out_frame_end,
  output int          fail_count,
  output int          pending_beats
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_beat_t;

  frame_beat_t expected_beats[$];

  logic [15:0] frame_crc;
  logic [7:0]  words_due;
  logic        write_pending;
  int          mismatches;

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ mrf_pkg::CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    frame_crc = crc16_next(frame_crc, b);
    expected_beats.push_back('{value: b, last: 1'b0});
  endtask

  task automatic queue_crc();
    expected_beats.push_back('{value: frame_crc[7:0], last: 1'b0});
    expected_beats.push_back('{value: frame_crc[15:8], last: 1'b1});
    frame_crc = mrf_pkg::CRC_INIT;
  endtask

  task automatic encode_request(input logic kind, input logic [7:0] slave,
                                input logic [7:0] fc, input logic [15:0] start,
                                input logic [15:0] qty, input logic [15:0] word);
    logic [15:0] field;
    logic [7:0]  count;
    if (kind != mrf_pkg::KIND_HEADER) begin
      // data words outside an open write are dropped
      if (!write_pending) return;
      queue_byte(word[15:8]);
      queue_byte(word[7:0]);
      words_due = words_due - 8'd1;
      if (words_due == 8'd0) begin
        write_pending = 1'b0;
        queue_crc();
      end
      return;
    end
    // any header abandons an unfinished write
    frame_crc     = mrf_pkg::CRC_INIT;
    words_due     = 8'd0;
    write_pending = 1'b0;
    case (fc)
      mrf_pkg::FC_READ_COILS, mrf_pkg::FC_READ_INPUTS, mrf_pkg::FC_READ_HOLDING,
      mrf_pkg::FC_WRITE_COIL, mrf_pkg::FC_WRITE_REG: begin
        field = (fc == mrf_pkg::FC_WRITE_COIL || fc == mrf_pkg::FC_WRITE_REG) ? word : qty;
        queue_byte(slave);
        queue_byte(fc);
        queue_byte(start[15:8]);
        queue_byte(start[7:0]);
        queue_byte(field[15:8]);
        queue_byte(field[7:0]);
        queue_crc();
      end
      mrf_pkg::FC_WRITE_MULTI: begin
        count = qty[7:0];
        queue_byte(slave);
        queue_byte(fc);
        queue_byte(start[15:8]);
        queue_byte(start[7:0]);
        queue_byte(8'h00);
        queue_byte(count);
        queue_byte({count[6:0], 1'b0});
        if (count == 8'd0) begin
          queue_crc();
        end else begin
          words_due     = count;
          write_pending = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 100) begin
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_beat_t head;
    if (!rst_n) begin
      expected_beats.delete();
      frame_crc     = mrf_pkg::CRC_INIT;
      words_due     = 8'd0;
      write_pending = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_request(in_kind, in_slave_address, in_function_code, in_start_address,
                       in_quantity, in_data_word);
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("frame byte with nothing pending", int'(out_frame_byte), 0);
        end else begin
          head = expected_beats.pop_front();
          if (out_frame_byte !== head.value) begin
            report_mismatch("frame_byte", int'(out_frame_byte), int'(head.value));
          end
          if (out_frame_end !== head.last) begin
            report_mismatch("frame_end", int'(out_frame_end), int'(head.last));
          end
        end
      end
    end
    pending_beats <= expected_beats.size();
    fail_count    <= mismatches;
  end

endmodule

@@ dv/modbus_request_framer_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modbus_request_framer_tb - top level bench of the Modbus request framer
// Drives directed requests, then random request sequences (mostly complete
// frames and multi-register writes, some abandoned writes, stray words and
// unsupported codes) under three idle patterns, with one long output stall.
// The frame_checker beside the block predicts and compares the byte stream.
// ---------------------------------------------------------------------------

module modbus_request_framer_tb;

  localparam logic KIND_WORD    = ~mrf_pkg::KIND_HEADER;
  localparam int   QUIET_LIMIT  = 5000;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   HOLD_WORDS   = 32;
  localparam int   DRAIN_CYCLES = 16;
  localparam int   PHASE_ITEMS  = 110;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [7:0]  in_slave_address;
  logic [7:0]  in_function_code;
  logic [15:0] in_start_address;
  logic [15:0] in_quantity;
  logic [15:0] in_data_word;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_frame_byte;
  logic        out_frame_end;

  int fail_count;
  int pending_beats;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;
  int quiet_cycles  = 0;

  modbus_request_framer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_slave_address (in_slave_address),
    .in_function_code (in_function_code),
    .in_start_address (in_start_address),
    .in_quantity      (in_quantity),
    .in_data_word     (in_data_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_frame_end    (out_frame_end)
  );

  frame_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_slave_address (in_slave_address),
    .in_function_code (in_function_code),
    .in_start_address (in_start_address),
    .in_quantity      (in_quantity),
    .in_data_word     (in_data_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_byte   (out_frame_byte),
    .out_frame_end    (out_frame_end),
    .fail_count       (fail_count),
    .pending_beats    (pending_beats)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random back-pressure, or one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one beat on the request channel; valid only drops when idling
  task automatic offer(input logic kind, input logic [7:0] slave, input logic [7:0] fc,
                       input logic [15:0] start, input logic [15:0] qty,
                       input logic [15:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_slave_address <= slave;
    in_function_code <= fc;
    in_start_address <= start;
    in_quantity      <= qty;
    in_data_word     <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_header(input logic [7:0] slave, input logic [7:0] fc,
                             input logic [15:0] start, input logic [15:0] qty,
                             input logic [15:0] word);
    offer(mrf_pkg::KIND_HEADER, slave, fc, start, qty, word);
  endtask

  task automatic send_word(input logic [15:0] word);
    offer(KIND_WORD, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), word);
  endtask

  task automatic directed_requests();
    send_header(8'h00, mrf_pkg::FC_READ_COILS, 16'h0000, 16'h0000, 16'hFFFF);
    send_header(8'hFF, mrf_pkg::FC_READ_INPUTS, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_header(8'h11, mrf_pkg::FC_READ_HOLDING, 16'h006B, 16'h0003, 16'h5A5A);
    send_header(8'h01, mrf_pkg::FC_WRITE_COIL, 16'h00AC, 16'hFFFF, 16'hFF00);
    send_header(8'hF7, mrf_pkg::FC_WRITE_REG, 16'hFFFF, 16'h1234, 16'h0000);
    // zero-count write with the upper quantity byte set: header plus CRC
    send_header(8'h2A, mrf_pkg::FC_WRITE_MULTI, 16'h0001, 16'h0100, 16'hFFFF);
    send_header(8'h11, mrf_pkg::FC_WRITE_MULTI, 16'h0001, 16'h0002, 16'h0000);
    send_word(16'h000A);
    send_word(16'hFFFF);
    // stray word, nothing open
    send_word(16'hBEEF);
    // count 255 (byte count wraps to 0xFE), abandoned by a read
    send_header(8'h80, mrf_pkg::FC_WRITE_MULTI, 16'h8000, 16'hFFFF, 16'h0000);
    send_word(16'h0000);
    send_word(16'h8001);
    send_header(8'h7F, mrf_pkg::FC_READ_HOLDING, 16'h7FFF, 16'h007D, 16'h0000);
    // open write dropped by an unsupported code, then a stray word
    send_header(8'h05, mrf_pkg::FC_WRITE_MULTI, 16'h0010, 16'h0003, 16'h0000);
    send_word(16'h5555);
    send_header(8'h05, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_word(16'hAAAA);
    send_header(8'h33, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_header(8'h33, 8'h04, 16'h1111, 16'h2222, 16'h3333);
    send_header(8'h33, 8'h90, 16'h4444, 16'h5555, 16'h6666);
    send_header(8'hC3, mrf_pkg::FC_WRITE_MULTI, 16'hFFFF, 16'hFE01, 16'hFFFF);
    send_word(16'h1234);
  endtask

  task automatic random_sequence(inout int counted);
    int         pick;
    int         count;
    int         n_words;
    logic [7:0] fc;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      case ($urandom_range(0, 4))
        0:       fc = mrf_pkg::FC_READ_COILS;
        1:       fc = mrf_pkg::FC_READ_INPUTS;
        2:       fc = mrf_pkg::FC_READ_HOLDING;
        3:       fc = mrf_pkg::FC_WRITE_COIL;
        default: fc = mrf_pkg::FC_WRITE_REG;
      endcase
      send_header(8'($urandom), fc, 16'($urandom), 16'($urandom), 16'($urandom));
      counted++;
    end else if (pick < 85) begin
      count = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4) : $urandom_range(5, 30);
      // now and then cut the write short; the next header abandons it
      n_words = ($urandom_range(0, 6) != 0 || count == 0) ? count
                                                           : $urandom_range(0, count - 1);
      send_header(8'($urandom), mrf_pkg::FC_WRITE_MULTI, 16'($urandom),
                  {8'($urandom), 8'(count)}, 16'($urandom));
      counted++;
      repeat (n_words) begin
        send_word(16'($urandom));
        counted++;
      end
    end else if (pick < 93) begin
      send_word(16'($urandom));
    end else begin
      do fc = 8'($urandom);
      while (fc inside {mrf_pkg::FC_READ_COILS, mrf_pkg::FC_READ_INPUTS,
                        mrf_pkg::FC_READ_HOLDING, mrf_pkg::FC_WRITE_COIL,
                        mrf_pkg::FC_WRITE_REG, mrf_pkg::FC_WRITE_MULTI});
      send_header(8'($urandom), fc, 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_phase(input int n_items);
    int counted;
    counted = 0;
    while (counted < n_items) random_sequence(counted);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= mrf_pkg::KIND_HEADER;
    in_slave_address <= 8'h00;
    in_function_code <= 8'h00;
    in_start_address <= 16'h0000;
    in_quantity      <= 16'h0000;
    in_data_word     <= 16'h0000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 11;
    recv_idle_pct = 70;
    directed_requests();
    run_phase(PHASE_ITEMS);

    send_idle_pct = 70;
    recv_idle_pct = 11;
    run_phase(PHASE_ITEMS);

    // no idling; the receiver stalls for a long stretch while a long
    // multi-register write is offered, so the framer backs up into its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    send_header(8'($urandom), mrf_pkg::FC_WRITE_MULTI, 16'($urandom),
                {8'($urandom), 8'(HOLD_WORDS)}, 16'($urandom));
    repeat (HOLD_WORDS) send_word(16'($urandom));
    run_phase(PHASE_ITEMS);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
